>>> hw/rtl/qsli_pkg.sv
// Shared types, operation codes and quadrature constants of the quad surface load integrator.
package qsli_pkg;

   localparam logic [3:0] OP_NOP   = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_TAN_A = 4'd2;
   localparam logic [3:0] OP_TAN_B = 4'd3;
   localparam logic [3:0] OP_MUL   = 4'd4;
   localparam logic [3:0] OP_CROSS = 4'd5;
   localparam logic [3:0] OP_SQ    = 4'd6;
   localparam logic [3:0] OP_SQRT  = 4'd7;
   localparam logic [3:0] OP_ACC   = 4'd8;
   localparam logic [3:0] OP_VAL   = 4'd9;
   localparam logic [3:0] OP_FIN   = 4'd10;

   localparam logic [16:0] GAUSS_LO = 17'd13849;
   localparam logic [16:0] GAUSS_HI = 17'd51687;
   localparam logic [16:0] ONE_Q16  = 17'd65536;

   localparam logic [31:0] SHAPE_LL = 32'd191794801;
   localparam logic [31:0] SHAPE_LH = 32'd715813263;
   localparam logic [31:0] SHAPE_HH = 32'd2671545969;

   typedef struct packed {
      logic       go;
      logic [3:0] op;
      logic [1:0] q;
      logic [2:0] idx;
   } cmd_type;

   function automatic logic [31:0] shape_val(input logic [1:0] q, input logic [1:0] k);
      logic f1_hi;
      logic f2_hi;
      logic [31:0] v;
      unique case (k)
         2'd0: begin
            f1_hi = ~q[0];
            f2_hi = ~q[1];
         end
         2'd1: begin
            f1_hi = q[0];
            f2_hi = ~q[1];
         end
         2'd2: begin
            f1_hi = q[0];
            f2_hi = q[1];
         end
         default: begin
            f1_hi = ~q[0];
            f2_hi = q[1];
         end
      endcase
      if (f1_hi && f2_hi) begin
         v = SHAPE_HH;
      end else if (f1_hi || f2_hi) begin
         v = SHAPE_LH;
      end else begin
         v = SHAPE_LL;
      end
      return v;
   endfunction

endpackage

>>> hw/rtl/qsli_mul.sv
// Iterative signed 64 by 64 multiplier, sixteen bits of one operand per cycle.
module qsli_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  a,
   input  logic signed [63:0]  b,
   output logic                done,
   output logic signed [127:0] prod
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic [63:0]  ma_ff, ma_in;
   logic [63:0]  mb_ff, mb_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [79:0]  part;

   assign part = ma_ff * mb_ff[63:48];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         ma_in   = a[63] ? 64'(-a) : 64'(a);
         mb_in   = b[63] ? 64'(-b) : 64'(b);
         neg_in  = a[63] ^ b[63];
         acc_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == 3'd4) begin
            acc_in  = neg_ff ? 128'(-acc_ff) : acc_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = {acc_ff[111:0], 16'd0} + 128'(part);
            mb_in  = {mb_ff[47:0], 16'd0};
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = signed'(acc_ff);

endmodule

>>> hw/rtl/qsli_sqrt.sv
// Restoring integer square root of a 128-bit radicand, one result bit per cycle.
module qsli_sqrt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] radicand,
   output logic         done,
   output logic [63:0]  root
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [127:0] rad_ff, rad_in;
   logic [65:0]  rem_ff, rem_in;
   logic [63:0]  root_ff, root_in;
   logic [67:0]  rem_w;
   logic [67:0]  trial;

   assign rem_w = {rem_ff, rad_ff[127:126]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[125:0], 2'b00};
         if (rem_w >= trial) begin
            rem_in  = 66'(rem_w - trial);
            root_in = {root_ff[62:0], 1'b1};
         end else begin
            rem_in  = rem_w[65:0];
            root_in = {root_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> hw/rtl/qsli_dp.sv
// Datapath: corner storage, tangents, cross product, area, weighted sums and result beats.
module qsli_dp #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int NODE_ID_BITS    = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  qsli_pkg::cmd_type        cmd,
   input  logic signed [31:0]       coord_x,
   input  logic signed [31:0]       coord_y,
   input  logic signed [31:0]       coord_z,
   input  logic [NODE_ID_BITS-1:0]  node_id,
   input  logic signed [31:0]       element_value,
   input  logic signed [31:0]       scale,
   input  logic [4:0]               stride,
   input  logic [3:0]               component_slot,
   output logic                     done,
   output logic                     rsp_valid,
   output logic [35:0]              rsp_out_index,
   output logic signed [63:0]       rsp_contribution,
   output logic                     rsp_last
);

   localparam int IW = NODE_ID_BITS + 6;
   localparam int EW = (IW > 36) ? IW : 36;

   logic signed [31:0]      cx_ff [4];
   logic signed [31:0]      cy_ff [4];
   logic signed [31:0]      cz_ff [4];
   logic [NODE_ID_BITS-1:0] node_ff [4];
   logic signed [31:0]      ev_ff;
   logic [3:0]              op_ff;
   logic [1:0]              q_ff;
   logic [2:0]              idx_ff;
   logic signed [50:0]      tacc_ff, tacc_in;
   logic signed [33:0]      ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [33:0]      ax_in, ay_in, az_in, bx_in, by_in, bz_in;
   logic signed [127:0]     prod_ff, prod_in;
   logic [63:0]             cm_ff, cm_in;
   logic [127:0]            rad_ff, rad_in;
   logic [63:0]             area_ff, area_in;
   logic [127:0]            acc_ff [4];
   logic [127:0]            acc_in [4];
   logic signed [63:0]      val_ff, val_in;
   logic                    sdone_ff, sdone_in;
   logic                    rv_ff, rv_in;
   logic [35:0]             ridx_ff, ridx_in;
   logic signed [63:0]      rcon_ff, rcon_in;
   logic                    rlast_ff, rlast_in;

   logic signed [31:0]  p0, p1, p2, p3;
   logic [16:0]         s_w, t_w, w_a, w_b, w_sel;
   logic signed [32:0]  d_a, d_b, d_sel;
   logic signed [50:0]  prod_w;
   logic signed [51:0]  tsum;
   logic signed [33:0]  tnew;
   logic                mul_start, mul_done, sqrt_start, sqrt_done;
   logic signed [63:0]  mul_a, mul_b;
   logic signed [127:0] mul_p;
   logic [63:0]         sq_root;
   logic signed [127:0] xdiff, xsh, fsh;
   logic signed [63:0]  x64;
   logic [EW-1:0]       idx_full;

   always_comb begin
      unique case (cmd.idx[1:0])
         2'd0: begin
            p0 = cx_ff[0];
            p1 = cx_ff[1];
            p2 = cx_ff[2];
            p3 = cx_ff[3];
         end
         2'd1: begin
            p0 = cy_ff[0];
            p1 = cy_ff[1];
            p2 = cy_ff[2];
            p3 = cy_ff[3];
         end
         default: begin
            p0 = cz_ff[0];
            p1 = cz_ff[1];
            p2 = cz_ff[2];
            p3 = cz_ff[3];
         end
      endcase
      s_w = cmd.q[0] ? qsli_pkg::GAUSS_HI : qsli_pkg::GAUSS_LO;
      t_w = cmd.q[1] ? qsli_pkg::GAUSS_HI : qsli_pkg::GAUSS_LO;
      if (cmd.idx[2]) begin
         d_a = 33'(p1) - 33'(p0);
         d_b = 33'(p2) - 33'(p3);
         w_a = qsli_pkg::ONE_Q16 - t_w;
         w_b = t_w;
      end else begin
         d_a = 33'(p3) - 33'(p0);
         d_b = 33'(p2) - 33'(p1);
         w_a = qsli_pkg::ONE_Q16 - s_w;
         w_b = s_w;
      end
      w_sel = (cmd.op == qsli_pkg::OP_TAN_A) ? w_a : w_b;
      d_sel = (cmd.op == qsli_pkg::OP_TAN_A) ? d_a : d_b;
      prod_w = $signed({1'b0, w_sel}) * d_sel;
      tsum   = 52'(tacc_ff) + 52'(prod_w);
      tnew   = tsum[49:16];
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         qsli_pkg::OP_MUL: begin
            unique case (cmd.idx[1:0])
               2'd0: begin
                  mul_a = 64'(ay_ff);
                  mul_b = 64'(bz_ff);
               end
               2'd1: begin
                  mul_a = 64'(az_ff);
                  mul_b = 64'(bx_ff);
               end
               default: begin
                  mul_a = 64'(ax_ff);
                  mul_b = 64'(by_ff);
               end
            endcase
         end
         qsli_pkg::OP_CROSS: begin
            unique case (cmd.idx[1:0])
               2'd0: begin
                  mul_a = 64'(az_ff);
                  mul_b = 64'(by_ff);
               end
               2'd1: begin
                  mul_a = 64'(ax_ff);
                  mul_b = 64'(bz_ff);
               end
               default: begin
                  mul_a = 64'(ay_ff);
                  mul_b = 64'(bx_ff);
               end
            endcase
         end
         qsli_pkg::OP_SQ: begin
            mul_a = signed'(cm_ff);
            mul_b = signed'(cm_ff);
         end
         qsli_pkg::OP_ACC: begin
            mul_a = signed'(area_ff);
            mul_b = signed'({32'd0, qsli_pkg::shape_val(cmd.q, cmd.idx[1:0])});
         end
         qsli_pkg::OP_VAL: begin
            mul_a = 64'(scale);
            mul_b = 64'(ev_ff);
         end
         qsli_pkg::OP_FIN: begin
            mul_a = val_ff;
            mul_b = signed'(acc_ff[cmd.idx[1:0]][97:34]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_start  = cmd.go && ((cmd.op == qsli_pkg::OP_MUL) || (cmd.op == qsli_pkg::OP_CROSS)
                       || (cmd.op == qsli_pkg::OP_SQ) || (cmd.op == qsli_pkg::OP_ACC)
                       || (cmd.op == qsli_pkg::OP_VAL) || (cmd.op == qsli_pkg::OP_FIN));
   assign sqrt_start = cmd.go && (cmd.op == qsli_pkg::OP_SQRT);

   qsli_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   qsli_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (rad_ff),
      .done     (sqrt_done),
      .root     (sq_root)
   );

   assign xdiff = prod_ff - mul_p;
   assign xsh   = xdiff >>> COORD_FRAC_BITS;
   assign x64   = xsh[63:0];
   assign fsh   = mul_p >>> COORD_FRAC_BITS;
   assign idx_full = (EW'(node_ff[idx_ff[1:0]]) * EW'(stride)) + EW'(component_slot);

   always_comb begin
      tacc_in  = tacc_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      az_in    = az_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      bz_in    = bz_ff;
      prod_in  = prod_ff;
      cm_in    = cm_ff;
      rad_in   = rad_ff;
      area_in  = area_ff;
      val_in   = val_ff;
      rv_in    = 1'b0;
      ridx_in  = ridx_ff;
      rcon_in  = rcon_ff;
      rlast_in = rlast_ff;
      for (int i = 0; i < 4; i++) begin
         acc_in[i] = acc_ff[i];
      end
      sdone_in = cmd.go && ((cmd.op == qsli_pkg::OP_TAN_A) || (cmd.op == qsli_pkg::OP_TAN_B)
                 || (cmd.op == qsli_pkg::OP_NOP));
      if (cmd.go && (cmd.op == qsli_pkg::OP_TAN_A)) begin
         tacc_in = prod_w;
      end
      if (cmd.go && (cmd.op == qsli_pkg::OP_TAN_B)) begin
         unique case (cmd.idx)
            3'd0:    ax_in = tnew;
            3'd1:    ay_in = tnew;
            3'd2:    az_in = tnew;
            3'd4:    bx_in = tnew;
            3'd5:    by_in = tnew;
            default: bz_in = tnew;
         endcase
      end
      if (sqrt_start) begin
         rad_in = '0;
      end
      if (sqrt_done) begin
         area_in = sq_root;
      end
      if (mul_done) begin
         unique case (op_ff)
            qsli_pkg::OP_MUL:   prod_in = mul_p;
            qsli_pkg::OP_CROSS: cm_in = x64[63] ? 64'(-x64) : 64'(x64);
            qsli_pkg::OP_SQ:    rad_in = rad_ff + 128'(mul_p);
            qsli_pkg::OP_ACC: begin
               acc_in[idx_ff[1:0]] = ((q_ff == 2'd0) ? 128'd0 : acc_ff[idx_ff[1:0]])
                                     + 128'(mul_p);
            end
            qsli_pkg::OP_VAL:   val_in = mul_p[63:0];
            qsli_pkg::OP_FIN: begin
               rv_in    = 1'b1;
               ridx_in  = idx_full[35:0];
               rlast_in = (idx_ff[1:0] == 2'd3);
               if (fsh[127:63] == {65{fsh[127]}}) begin
                  rcon_in = fsh[63:0];
               end else if (fsh[127]) begin
                  rcon_in = {1'b1, 63'd0};
               end else begin
                  rcon_in = {1'b0, {63{1'b1}}};
               end
            end
            default: prod_in = prod_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sdone_ff <= 1'b0;
         rv_ff    <= 1'b0;
         rad_ff   <= '0;
         op_ff    <= qsli_pkg::OP_NOP;
      end else begin
         sdone_ff <= sdone_in;
         rv_ff    <= rv_in;
         rad_ff   <= rad_in;
         if (cmd.go) begin
            op_ff <= cmd.op;
         end
      end
      if (cmd.go) begin
         q_ff   <= cmd.q;
         idx_ff <= cmd.idx;
      end
      if (cmd.go && (cmd.op == qsli_pkg::OP_LOAD)) begin
         cx_ff[cmd.idx[1:0]]   <= coord_x;
         cy_ff[cmd.idx[1:0]]   <= coord_y;
         cz_ff[cmd.idx[1:0]]   <= coord_z;
         node_ff[cmd.idx[1:0]] <= node_id;
         ev_ff                 <= element_value;
      end
      tacc_ff  <= tacc_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      az_ff    <= az_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      bz_ff    <= bz_in;
      prod_ff  <= prod_in;
      cm_ff    <= cm_in;
      area_ff  <= area_in;
      val_ff   <= val_in;
      ridx_ff  <= ridx_in;
      rcon_ff  <= rcon_in;
      rlast_ff <= rlast_in;
      for (int i = 0; i < 4; i++) begin
         acc_ff[i] <= acc_in[i];
      end
   end

   assign done             = sdone_ff | mul_done | sqrt_done;
   assign rsp_valid        = rv_ff;
   assign rsp_out_index    = ridx_ff;
   assign rsp_contribution = rcon_ff;
   assign rsp_last         = rlast_ff;

endmodule

>>> hw/rtl/qsli_ctrl.sv
// Controller: corner counting and the operation sequence over Gauss points and corners.
module qsli_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              done,
   output logic              busy,
   output qsli_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;

   localparam logic [1:0] PH_Q   = 2'd0;
   localparam logic [1:0] PH_VAL = 2'd1;
   localparam logic [1:0] PH_FIN = 2'd2;

   localparam logic [4:0] LAST_STEP = 5'd25;

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] q_ff, q_in;
   logic [1:0] k_ff, k_in;
   logic [3:0] dec_op;
   logic [2:0] dec_idx;
   logic [2:0] tan_idx;

   always_comb begin
      unique case (step_ff[4:1])
         4'd0:    tan_idx = 3'd0;
         4'd1:    tan_idx = 3'd1;
         4'd2:    tan_idx = 3'd2;
         4'd3:    tan_idx = 3'd4;
         4'd4:    tan_idx = 3'd5;
         default: tan_idx = 3'd6;
      endcase
      dec_op  = qsli_pkg::OP_NOP;
      dec_idx = 3'd0;
      unique case (phase_ff)
         PH_VAL: dec_op = qsli_pkg::OP_VAL;
         PH_FIN: begin
            dec_op  = qsli_pkg::OP_FIN;
            dec_idx = {1'b0, k_ff};
         end
         default: begin
            if (step_ff < 5'd12) begin
               dec_op  = step_ff[0] ? qsli_pkg::OP_TAN_B : qsli_pkg::OP_TAN_A;
               dec_idx = tan_idx;
            end else begin
               unique case (step_ff)
                  5'd12: dec_op = qsli_pkg::OP_MUL;
                  5'd13: dec_op = qsli_pkg::OP_CROSS;
                  5'd14: dec_op = qsli_pkg::OP_SQ;
                  5'd15: begin
                     dec_op  = qsli_pkg::OP_MUL;
                     dec_idx = 3'd1;
                  end
                  5'd16: begin
                     dec_op  = qsli_pkg::OP_CROSS;
                     dec_idx = 3'd1;
                  end
                  5'd17: dec_op = qsli_pkg::OP_SQ;
                  5'd18: begin
                     dec_op  = qsli_pkg::OP_MUL;
                     dec_idx = 3'd2;
                  end
                  5'd19: begin
                     dec_op  = qsli_pkg::OP_CROSS;
                     dec_idx = 3'd2;
                  end
                  5'd20: dec_op = qsli_pkg::OP_SQ;
                  5'd21: dec_op = qsli_pkg::OP_SQRT;
                  5'd22: dec_op = qsli_pkg::OP_ACC;
                  5'd23: begin
                     dec_op  = qsli_pkg::OP_ACC;
                     dec_idx = 3'd1;
                  end
                  5'd24: begin
                     dec_op  = qsli_pkg::OP_ACC;
                     dec_idx = 3'd2;
                  end
                  5'd25: begin
                     dec_op  = qsli_pkg::OP_ACC;
                     dec_idx = 3'd3;
                  end
                  default: dec_op = qsli_pkg::OP_NOP;
               endcase
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      cmd.go   = 1'b0;
      cmd.op   = qsli_pkg::OP_NOP;
      cmd.q    = q_ff;
      cmd.idx  = 3'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.go  = 1'b1;
               cmd.op  = qsli_pkg::OP_LOAD;
               cmd.idx = {1'b0, cnt_ff};
               cnt_in  = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_in = S_ISSUE;
                  phase_in = PH_Q;
                  step_in  = 5'd0;
                  q_in     = 2'd0;
                  k_in     = 2'd0;
               end
            end
         end
         S_ISSUE: begin
            cmd.go   = 1'b1;
            cmd.op   = dec_op;
            cmd.idx  = dec_idx;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (done) begin
               state_in = S_ISSUE;
               unique case (phase_ff)
                  PH_VAL: phase_in = PH_FIN;
                  PH_FIN: begin
                     k_in = k_ff + 2'd1;
                     if (k_ff == 2'd3) begin
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     if (step_ff == LAST_STEP) begin
                        step_in = 5'd0;
                        q_in    = q_ff + 2'd1;
                        if (q_ff == 2'd3) begin
                           phase_in = PH_VAL;
                        end
                     end else begin
                        step_in = step_ff + 5'd1;
                     end
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_Q;
         cnt_ff   <= 2'd0;
         step_ff  <= 5'd0;
         q_ff     <= 2'd0;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         q_ff     <= q_in;
         k_ff     <= k_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> hw/rtl/quad_surface_load_integrator.sv
// Top level of the quad surface load integrator with its register port.
// Corners are taken one per beat while busy is low. After the fourth corner busy stays high
// while each of the four Gauss points passes through the shared multiplier and the 64-step
// square root, and the four result beats then follow. The receiver cannot stall, so every
// result beat is shown on rsp_valid for a single cycle and must be taken then.
module quad_surface_load_integrator #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int NODE_ID_BITS    = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic [31:0]        req_node_id,
   input  logic signed [31:0] req_element_value,
   output logic               rsp_valid,
   output logic [35:0]        rsp_out_index,
   output logic signed [63:0] rsp_contribution,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic [1:0] REG_SCALE  = 2'd0;
   localparam logic [1:0] REG_STRIDE = 2'd1;
   localparam logic [1:0] REG_SLOT   = 2'd2;

   logic signed [31:0] scale_ff, scale_in;
   logic [4:0]         stride_ff, stride_in;
   logic [3:0]         slot_ff, slot_in;
   logic               wr;
   logic               done;
   qsli_pkg::cmd_type  cmd;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      scale_in  = scale_ff;
      stride_in = stride_ff;
      slot_in   = slot_ff;
      if (wr) begin
         unique case (paddr[3:2])
            REG_SCALE:  scale_in = signed'(pwdata);
            REG_STRIDE: stride_in = pwdata[4:0];
            REG_SLOT:   slot_in = pwdata[3:0];
            default:    scale_in = scale_ff;
         endcase
      end
      unique case (paddr[3:2])
         REG_SCALE:  prdata = scale_ff;
         REG_STRIDE: prdata = {27'd0, stride_ff};
         REG_SLOT:   prdata = {28'd0, slot_ff};
         default:    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= 32'sd65536;
         stride_ff <= 5'd1;
         slot_ff   <= 4'd0;
      end else begin
         scale_ff  <= scale_in;
         stride_ff <= stride_in;
         slot_ff   <= slot_in;
      end
   end

   qsli_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .done  (done),
      .busy  (busy),
      .cmd   (cmd)
   );

   qsli_dp #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .NODE_ID_BITS    (NODE_ID_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .coord_x          (req_coord_x),
      .coord_y          (req_coord_y),
      .coord_z          (req_coord_z),
      .node_id          (req_node_id[NODE_ID_BITS-1:0]),
      .element_value    (req_element_value),
      .scale            (scale_ff),
      .stride           (stride_ff),
      .component_slot   (slot_ff),
      .done             (done),
      .rsp_valid        (rsp_valid),
      .rsp_out_index    (rsp_out_index),
      .rsp_contribution (rsp_contribution),
      .rsp_last         (rsp_last)
   );

endmodule
